/* src/cas_pkg.sv */
// Package for the circle arc step block: pipeline depths, fixed-point constants,
// the CORDIC arc table and the side-band word that travels beside the math.
// No dependencies.
`timescale 1ns / 1ps
package cas_pkg;

  localparam int RootStages  = 33;
  localparam int DivStages   = 108;
  localparam int DivFracBits = 44;
  localparam int MaxStages   = 32;

  localparam logic [30:0] TwoPiQ28      = 31'd1686629713;
  localparam logic [33:0] CordicGainQ30 = 34'd652032874;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] lz;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic        [63:0] p;
    logic               neg;
    logic               zero;
  } side_t;

  function automatic logic [31:0] arc_angle(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* src/cas_root.sv */
// Pipelined restoring square root: one result bit per stage, 33 stages.
// Depends on cas_pkg for the stage count.
`timescale 1ns / 1ps
module cas_root (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [65:0] rad_i,
  output logic [32:0] root_o
);

  localparam int N = cas_pkg::RootStages;

  logic [65:0] rad_q [1:N];
  logic [35:0] rem_q [1:N];
  logic [32:0] res_q [1:N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int K = N - 1 - g;
    logic [65:0] rad_in;
    logic [35:0] rem_in;
    logic [32:0] res_in;
    logic [37:0] rem_sh;
    logic [37:0] trial;
    logic        ge;

    if (g == 0) begin : g_first
      assign rad_in = rad_i;
      assign rem_in = '0;
      assign res_in = '0;
    end else begin : g_next
      assign rad_in = rad_q[g];
      assign rem_in = rem_q[g];
      assign res_in = res_q[g];
    end

    assign rem_sh = {rem_in, rad_in[2*K+1:2*K]};
    assign trial  = {3'b000, res_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g+1] <= rad_in;
        rem_q[g+1] <= ge ? 36'(rem_sh - trial) : rem_sh[35:0];
        res_q[g+1] <= {res_in[31:0], ge};
      end
    end
  end

  assign root_o = res_q[N];

endmodule

/* src/cas_div.sv */
// Pipelined restoring divider giving floor(num * 2^44 / den) mod 2^32,
// one quotient bit per stage. Depends on cas_pkg for the stage count.
`timescale 1ns / 1ps
module cas_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [31:0] quo_o
);

  localparam int N = cas_pkg::DivStages;
  localparam int F = cas_pkg::DivFracBits;

  logic [63:0] num_q [1:N];
  logic [63:0] den_q [1:N];
  logic [63:0] rem_q [1:N];
  logic [31:0] quo_q [1:N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int J = N - 1 - g;
    logic [63:0] num_in;
    logic [63:0] den_in;
    logic [63:0] rem_in;
    logic [31:0] quo_in;
    logic        nbit;
    logic [64:0] rem_sh;
    logic        ge;

    if (g == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[g];
      assign den_in = den_q[g];
      assign rem_in = rem_q[g];
      assign quo_in = quo_q[g];
    end

    if (J >= F) begin : g_bit
      assign nbit = num_in[J-F];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign rem_sh = {rem_in, nbit};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g+1] <= num_in;
        den_q[g+1] <= den_in;
        rem_q[g+1] <= ge ? 64'(rem_sh - {1'b0, den_in}) : rem_sh[63:0];
        quo_q[g+1] <= {quo_in[30:0], ge};
      end
    end
  end

  assign quo_o = quo_q[N];

endmodule

/* src/cas_cordic.sv */
// Pipelined rotation-mode CORDIC on turn angles: one prepare stage that folds
// the angle into half a turn, then one stage per iteration. Depends on cas_pkg.
`timescale 1ns / 1ps
module cas_cordic #(
  parameter int Iter = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic        [31:0] ang_i,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  logic signed [33:0] x_q    [0:Iter];
  logic signed [33:0] y_q    [0:Iter];
  logic signed [32:0] z_q    [0:Iter];
  logic               flip_q [0:Iter];

  logic        flip;
  logic [31:0] ang_f;

  assign flip  = ang_i[31] ^ ang_i[30];
  assign ang_f = flip ? {~ang_i[31], ang_i[30:0]} : ang_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= signed'(cas_pkg::CordicGainQ30);
      y_q[0]    <= '0;
      z_q[0]    <= signed'({ang_f[31], ang_f});
      flip_q[0] <= flip;
    end
  end

  for (genvar g = 0; g < Iter; g++) begin : g_iter
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [32:0] at;

    assign xs = x_q[g] >>> g;
    assign ys = y_q[g] >>> g;
    assign at = signed'({1'b0, cas_pkg::arc_angle(5'(g))});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[g+1] <= flip_q[g];
        if (!z_q[g][32]) begin
          x_q[g+1] <= x_q[g] - ys;
          y_q[g+1] <= y_q[g] + xs;
          z_q[g+1] <= z_q[g] - at;
        end else begin
          x_q[g+1] <= x_q[g] + ys;
          y_q[g+1] <= y_q[g] - xs;
          z_q[g+1] <= z_q[g] + at;
        end
      end
    end
  end

  assign cos_o = flip_q[Iter] ? -x_q[Iter] : x_q[Iter];
  assign sin_o = flip_q[Iter] ? -y_q[Iter] : y_q[Iter];

endmodule

/* src/circle_arc_step.sv */
// Top level of the circle arc step block: input stage, squares, root, divider,
// CORDIC, rotation and output. Uses cas_pkg, cas_root, cas_div and cas_cordic.
`timescale 1ns / 1ps
// Each word gives a center, a last position, a speed, a time step and a
// direction, and one word comes back with the position moved along the circle.
// The block takes a word in every cycle and is fully pipelined; a result
// passes through the 33 root stages, 108 divider stages and the CORDIC
// chain. The whole pipeline halts while a finished word waits at the output.
module circle_arc_step #(
  parameter int ANGLE_ITERATIONS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // center_x, center_y, last_x, last_y, last_z, linear_speed, delta_time
  input  logic [223:0] s_axis_tdata_i,
  // clockwise
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // next_x, next_y, next_z
  output logic [95:0]  m_axis_tdata_o,
  // zero_radius
  output logic         m_axis_tuser_o
);

  localparam int Iter    = (ANGLE_ITERATIONS > cas_pkg::MaxStages) ?
                           cas_pkg::MaxStages : ANGLE_ITERATIONS;
  localparam int StRoot  = 3 + cas_pkg::RootStages;
  localparam int StDen   = StRoot + 1;
  localparam int StDiv   = StDen + cas_pkg::DivStages;
  localparam int StCord  = StDiv + Iter + 1;
  localparam int StProd  = StCord + 1;
  localparam int StSum   = StProd + 1;
  localparam int StOut   = StSum + 1;

  logic                en;
  logic [StOut:1]      vld_q;
  cas_pkg::side_t      side_q [1:StSum];
  cas_pkg::side_t      side_d;

  logic signed [31:0]  in_cx, in_cy, in_lx, in_ly, in_spd;
  logic        [31:0]  in_dt;
  logic signed [32:0]  dx, dy;
  logic        [32:0]  ax, ay;
  logic        [31:0]  spd_abs;

  logic        [32:0]  ax_q, ay_q;
  logic        [65:0]  sx_q, sy_q, sum_q;
  logic        [32:0]  root;
  logic        [63:0]  den_q, num_q;
  logic        [31:0]  quo;
  logic        [31:0]  ang;
  logic signed [33:0]  cos_v, sin_v;
  logic signed [66:0]  pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [67:0]  sumx, sumy;
  logic signed [37:0]  nx_q, ny_q;
  logic signed [38:0]  ox, oy;
  logic        [31:0]  ox_sat, oy_sat;
  logic        [95:0]  data_q;
  logic                zr_q;

  assign en              = !vld_q[StOut] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[StOut];
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = zr_q;

  assign in_cx  = signed'(s_axis_tdata_i[31:0]);
  assign in_cy  = signed'(s_axis_tdata_i[63:32]);
  assign in_lx  = signed'(s_axis_tdata_i[95:64]);
  assign in_ly  = signed'(s_axis_tdata_i[127:96]);
  assign in_spd = signed'(s_axis_tdata_i[191:160]);
  assign in_dt  = s_axis_tdata_i[223:192];

  assign dx      = {in_lx[31], in_lx} - {in_cx[31], in_cx};
  assign dy      = {in_ly[31], in_ly} - {in_cy[31], in_cy};
  assign ax      = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay      = dy[32] ? 33'(-dy) : 33'(dy);
  assign spd_abs = in_spd[31] ? 32'(-in_spd) : 32'(in_spd);

  always_comb begin
    side_d      = '0;
    side_d.cx   = in_cx;
    side_d.cy   = in_cy;
    side_d.lx   = in_lx;
    side_d.ly   = in_ly;
    side_d.lz   = signed'(s_axis_tdata_i[159:128]);
    side_d.dx   = dx;
    side_d.dy   = dy;
    side_d.p    = 64'(spd_abs) * 64'(in_dt);
    side_d.neg  = in_spd[31] ^ s_axis_tuser_i;
    side_d.zero = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[StOut-1:1], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_d;
      for (int k = 2; k <= StSum; k++) begin
        side_q[k] <= side_q[k-1];
      end
      ax_q  <= ax;
      ay_q  <= ay;
      sx_q  <= 66'(ax_q) * 66'(ax_q);
      sy_q  <= 66'(ay_q) * 66'(ay_q);
      sum_q <= sx_q + sy_q;
      den_q <= 64'(root) * 64'(cas_pkg::TwoPiQ28);
      num_q <= side_q[StRoot].p;
    end
  end

  cas_root u_root (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  cas_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  assign ang = side_q[StDiv].neg ? 32'(-quo) : quo;

  cas_cordic #(
    .Iter (Iter)
  ) u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  assign sumx = 68'(pxc_q) - 68'(pys_q) + 68'sd536870912;
  assign sumy = 68'(pxs_q) + 68'(pyc_q) + 68'sd536870912;

  assign ox = 39'(side_q[StSum].cx) + 39'(nx_q);
  assign oy = 39'(side_q[StSum].cy) + 39'(ny_q);

  always_comb begin
    if (ox > 39'sd2147483647) begin
      ox_sat = 32'h7FFFFFFF;
    end else if (ox < -39'sd2147483648) begin
      ox_sat = 32'h80000000;
    end else begin
      ox_sat = ox[31:0];
    end
    if (oy > 39'sd2147483647) begin
      oy_sat = 32'h7FFFFFFF;
    end else if (oy < -39'sd2147483648) begin
      oy_sat = 32'h80000000;
    end else begin
      oy_sat = oy[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxc_q <= 67'(side_q[StCord].dx) * 67'(cos_v);
      pys_q <= 67'(side_q[StCord].dy) * 67'(sin_v);
      pxs_q <= 67'(side_q[StCord].dx) * 67'(sin_v);
      pyc_q <= 67'(side_q[StCord].dy) * 67'(cos_v);
      nx_q  <= sumx[67:30];
      ny_q  <= sumy[67:30];
      zr_q  <= side_q[StSum].zero;
      if (side_q[StSum].zero) begin
        data_q <= {side_q[StSum].lz, side_q[StSum].ly, side_q[StSum].lx};
      end else begin
        data_q <= {side_q[StSum].lz, oy_sat, ox_sat};
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("Pipeline valid bits moved during a stall.");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StRoot] && !side_q[StRoot].zero |-> root != '0)
    else $error("Zero root for a nonzero offset.");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StDen] && !side_q[StDen].zero |-> den_q != '0)
    else $error("Zero divisor for a nonzero radius.");
`endif

endmodule
